// ----- sv/ptpq_pkg.sv -----
package ptpq_pkg;

  localparam int TaskW = 12;
  localparam int PerW  = 16;
  localparam int DueW  = 40;

  localparam logic [DueW-1:0] DueMax = {DueW{1'b1}};

  // mode field encoding
  localparam logic ModeRegister = 1'b0;
  localparam logic ModePop      = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [TaskW-1:0] task_id;
    logic [PerW-1:0]  period;
  } ptpq_in_t;

  typedef struct packed {
    logic [TaskW-1:0] out_task;
    logic [DueW-1:0]  due_time;
    logic             empty_res;
  } ptpq_out_t;

  typedef struct packed {
    logic [TaskW-1:0] task_id;
    logic [PerW-1:0]  period;
    logic [DueW-1:0]  due;
  } ptpq_entry_t;

  typedef enum logic {
    OP_INSERT,
    OP_POP
  } ptpq_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ptpq_state_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic        en;
    ptpq_op_e    op;
    ptpq_entry_t key;
  } ptpq_ctrl_t;

endpackage

// ----- sv/ptpq_cell.sv -----
module ptpq_cell (
  input  logic                  clk_i,
  input  ptpq_pkg::ptpq_ctrl_t  ctrl_i,
  input  logic                  valid_i,
  input  logic                  left_le_i,
  input  ptpq_pkg::ptpq_entry_t left_entry_i,
  input  logic                  right_le_i,
  input  ptpq_pkg::ptpq_entry_t right_entry_i,
  output logic                  le_o,
  output ptpq_pkg::ptpq_entry_t entry_o
);

  ptpq_pkg::ptpq_entry_t entry_q, entry_d;

  // stored key orders at or before the broadcast key
  assign le_o = valid_i &&
                ((entry_q.due < ctrl_i.key.due) ||
                 ((entry_q.due == ctrl_i.key.due) &&
                  (entry_q.task_id <= ctrl_i.key.task_id)));

  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      ptpq_pkg::OP_INSERT: begin
        if (le_o) begin
          entry_d = entry_q;
        end else if (left_le_i) begin
          entry_d = ctrl_i.key;
        end else begin
          entry_d = left_entry_i;
        end
      end
      ptpq_pkg::OP_POP: begin
        // head leaves, chain shifts left, reinserted key drops into place;
        // the head's own le is always set, so cell 0 takes the key if needed
        if (right_le_i) begin
          entry_d = right_entry_i;
        end else if (le_o) begin
          entry_d = ctrl_i.key;
        end else begin
          entry_d = entry_q;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      entry_q <= entry_d;
    end
  end

endmodule

// ----- sv/periodic_task_priority_queue.sv -----
// A pop result is registered at the edge that accepts the pop. A register
// item gives no result. An item that changes the chain passes key setup in
// IDLE, then one shift/insert step across all cells in EXEC, while the input
// stalls; an empty pop or a dropped register item leaves the FSM in IDLE.
// Reset clears the entry count and the output valid; the cell contents are
// not reset.
module periodic_task_priority_queue #(
  parameter int DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ptpq_pkg::ptpq_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ptpq_pkg::ptpq_out_t out_data_o
);

  localparam int CntW = $clog2(DEPTH + 1);

  ptpq_pkg::ptpq_state_e state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  ptpq_pkg::ptpq_op_e    op_q;
  ptpq_pkg::ptpq_entry_t key_q, key_d;
  logic                  out_valid_q;
  ptpq_pkg::ptpq_out_t   out_q, out_d;

  ptpq_pkg::ptpq_ctrl_t  ctrl;
  logic                  exec_en;
  ptpq_pkg::ptpq_entry_t entry_w [DEPTH];
  logic                  le_w    [DEPTH];

  logic                  in_fire, out_fire, is_pop, empty, full, go_exec;
  logic [ptpq_pkg::DueW:0] due_sum;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_q && !out_stall_i;
  assign is_pop   = (in_data_i.mode == ptpq_pkg::ModePop);
  assign empty    = (count_q == '0);
  assign full     = (count_q == CntW'(DEPTH));
  assign go_exec  = in_fire && (is_pop ? !empty : !full);

  assign due_sum = {1'b0, entry_w[0].due} + (ptpq_pkg::DueW + 1)'(entry_w[0].period);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ptpq_pkg::ST_IDLE: if (go_exec) state_d = ptpq_pkg::ST_EXEC;
      ptpq_pkg::ST_EXEC: state_d = ptpq_pkg::ST_IDLE;
      default:           state_d = ptpq_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall_o = 1'b1;
    exec_en    = 1'b0;
    case (state_q)
      ptpq_pkg::ST_IDLE: in_stall_o = out_valid_q && out_stall_i;
      ptpq_pkg::ST_EXEC: exec_en = 1'b1;
      default:           in_stall_o = 1'b1;
    endcase
  end

  assign ctrl = '{en: exec_en, op: op_q, key: key_q};

  always_comb begin
    key_d = key_q;
    if (is_pop) begin
      key_d.task_id = entry_w[0].task_id;
      key_d.period  = entry_w[0].period;
      key_d.due     = due_sum[ptpq_pkg::DueW] ? ptpq_pkg::DueMax
                                              : due_sum[ptpq_pkg::DueW-1:0];
    end else begin
      key_d.task_id = in_data_i.task_id;
      key_d.period  = in_data_i.period;
      key_d.due     = ptpq_pkg::DueW'(in_data_i.period);
    end
  end

  always_comb begin
    out_d = out_q;
    if (empty) begin
      out_d.out_task  = '0;
      out_d.due_time  = '0;
      out_d.empty_res = 1'b1;
    end else begin
      out_d.out_task  = entry_w[0].task_id;
      out_d.due_time  = entry_w[0].due;
      out_d.empty_res = 1'b0;
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.en && op_q == ptpq_pkg::OP_INSERT) count_d = count_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptpq_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      op_q        <= ptpq_pkg::OP_INSERT;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (in_fire && is_pop) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      if (go_exec) op_q <= is_pop ? ptpq_pkg::OP_POP : ptpq_pkg::OP_INSERT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_exec) key_q <= key_d;
    if (in_fire && is_pop) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  left_le, right_le, cell_valid;
    ptpq_pkg::ptpq_entry_t left_entry, right_entry;

    assign cell_valid = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_le    = 1'b1;
      assign left_entry = key_q;
    end else begin : g_mid_l
      assign left_le    = le_w[i-1];
      assign left_entry = entry_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_le    = 1'b0;
      assign right_entry = key_q;
    end else begin : g_mid_r
      assign right_le    = le_w[i+1];
      assign right_entry = entry_w[i+1];
    end

    ptpq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .valid_i       (cell_valid),
      .left_le_i     (left_le),
      .left_entry_i  (left_entry),
      .right_le_i    (right_le),
      .right_entry_i (right_entry),
      .le_o          (le_w[i]),
      .entry_o       (entry_w[i])
    );
  end

endmodule

// ----- sv/ptpq_checker.sv -----
module ptpq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input ptpq_pkg::ptpq_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ptpq_pkg::ptpq_out_t out_data_o
);

  logic in_acc, pop_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign pop_acc = in_acc && (in_data_i.mode == ptpq_pkg::ModePop);

  a_pop_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_acc |=> out_valid_o)
    else $error("pop item gave no result");

  a_reg_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.mode == ptpq_pkg::ModeRegister && !out_valid_o) |=> !out_valid_o)
    else $error("register item produced a result");

  a_busy_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_acc |=> (out_data_o.empty_res || in_stall_o))
    else $error("item accepted while reinsert pending");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.empty_res) |->
      (out_data_o.out_task == '0 && out_data_o.due_time == '0))
    else $error("empty result carries nonzero fields");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind periodic_task_priority_queue ptpq_checker u_ptpq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
